/* design/gskf_pkg.sv */
// Shared types and constants for the gated scalar Kalman filter.
// Used by the controller, the datapath, the divider and the top level.
package gskf_pkg;

  localparam int ALTITUDE_WIDTH = 24;

  localparam int VAR_W  = 32;   // Q16.16 variance
  localparam int GATE_W = 23;   // innovation gate
  localparam int MS_W   = 16;   // millisecond intervals
  localparam int RUN_W  = 8;    // reject run counter
  localparam int K_W    = 16;   // Q0.16 gain
  localparam int KQ_W   = K_W + 1;

  localparam int INNOV_W = ALTITUDE_WIDTH + 1;
  localparam int CMP_W   = (INNOV_W > GATE_W) ? INNOV_W : GATE_W;
  localparam int SUM_W   = CMP_W + 1;

  // shared multiplier and divider
  localparam int MUL_A_W   = VAR_W;
  localparam int MUL_B_W   = KQ_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int DVD_W     = VAR_W + MS_W;
  localparam int DVS_W     = VAR_W + 1;
  localparam int REM_W     = DVS_W + 1;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);
  localparam int PSUM_W    = DVD_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_VARIANCE      = 3'd0,
    CFG_GATE_LIMIT            = 3'd1,
    CFG_RESEED_COUNT          = 3'd2,
    CFG_MAX_INTERVAL_MS       = 3'd3,
    CFG_PROCESS_NOISE         = 3'd4,
    CFG_REFERENCE_INTERVAL_MS = 3'd5,
    CFG_MEASUREMENT_NOISE     = 3'd6,
    CFG_CONVERGED_VARIANCE    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [VAR_W-1:0]  initial_variance;
    logic [GATE_W-1:0] gate_limit;
    logic [RUN_W-1:0]  reseed_count;
    logic [MS_W-1:0]   max_interval_ms;
    logic [VAR_W-1:0]  process_noise;
    logic [MS_W-1:0]   reference_interval_ms;
    logic [VAR_W-1:0]  measurement_noise;
    logic [VAR_W-1:0]  converged_variance;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    initial_variance:      32'd6553600,
    gate_limit:            23'd12800,
    reseed_count:          8'd3,
    max_interval_ms:       16'd10000,
    process_noise:         32'd32768,
    reference_interval_ms: 16'd1000,
    measurement_noise:     32'd1638400,
    converged_variance:    32'd262144
  };

  typedef struct packed {
    logic                             mode;
    logic signed [ALTITUDE_WIDTH-1:0] measured_altitude;
    logic [MS_W-1:0]                  elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic                             accepted;
    logic signed [ALTITUDE_WIDTH-1:0] estimate;
    logic                             converged;
  } out_item_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EVAL,
    OP_MUL_NOISE,
    OP_DIV_NOISE,
    OP_PSUM,
    OP_DIV_GAIN,
    OP_GAIN,
    OP_MUL_STEP,
    OP_MUL_VAR,
    OP_UPDATE,
    OP_EMIT
  } dp_op_e;

  // how the captured beat is handled
  typedef enum logic [1:0] {
    CLS_CLEAR,
    CLS_SEED,
    CLS_REJECT,
    CLS_UPDATE
  } cls_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    cls_e cls;
    logic div_busy;
  } dp_sts_t;

endpackage

/* design/gskf_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on gskf_pkg for operand widths.
module gskf_div import gskf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [REM_W-1:0]     rem_init_i,
  input  logic [DVD_W-1:0]     dividend_i,
  input  logic [DVS_W-1:0]     divisor_i,
  input  logic [DIV_CNT_W-1:0] count_i,
  output logic [DVD_W-1:0]     quot_o,
  output logic                 busy_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DVD_W-1:0]     dvd_q, dvd_d;
  logic [DVD_W-1:0]     quot_q, quot_d;
  logic [DVS_W-1:0]     dvs_q, dvs_d;
  logic [REM_W-1:0]     rem_sh;
  logic                 ge;

  assign rem_sh = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
  assign ge     = rem_sh >= REM_W'(dvs_q);

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d  = count_i;
      rem_d  = rem_init_i;
      dvd_d  = dividend_i;
      quot_d = '0;
      dvs_d  = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      rem_d  = ge ? (rem_sh - REM_W'(dvs_q)) : rem_sh;
      dvd_d  = {dvd_q[DVD_W-2:0], 1'b0};
      quot_d = {quot_q[DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign quot_o = quot_q;
  assign busy_o = cnt_q != '0;

endmodule

/* design/gskf_dp.sv */
// Datapath: filter state, shared multiplier, shared divider and result register.
// Depends on gskf_pkg and gskf_div; driven by operations from gskf_ctrl.
module gskf_dp import gskf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  in_item_t  in_data_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output out_item_t out_data_o
);

  localparam logic [KQ_W-1:0] GAIN_ONE = KQ_W'(1) << K_W;

  // filter state
  logic                             init_q;
  logic signed [ALTITUDE_WIDTH-1:0] est_q;
  logic [VAR_W-1:0]                 var_q;
  logic [RUN_W-1:0]                 rrun_q;

  // captured beat and working registers
  logic                             mode_q;
  logic signed [ALTITUDE_WIDTH-1:0] meas_q;
  logic [MS_W-1:0]                  dt_q;
  logic                             acc_q;
  logic                             neg_q;
  logic [GATE_W-1:0]                mag_q;
  logic [PROD_W-1:0]                prod_q;
  logic [VAR_W-1:0]                 p_q;
  logic [DVS_W-1:0]                 denom_q;
  logic [K_W-1:0]                   k_q;
  logic [GATE_W-1:0]                step_q;
  out_item_t                        out_q;

  logic [INNOV_W-1:0] innov;
  logic [INNOV_W-1:0] mag_full;
  logic               gate_rej;
  logic [RUN_W-1:0]   rrun_inc;
  logic               reseed;
  cls_e               cls;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_d;

  logic                 div_start;
  logic [REM_W-1:0]     div_rem_init;
  logic [DVD_W-1:0]     div_dvd;
  logic [DVS_W-1:0]     div_dvs;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DVD_W-1:0]     quot;
  logic                 div_busy;
  logic [MS_W-1:0]      ref_eff;

  logic [PSUM_W-1:0] psum;
  logic [VAR_W-1:0]  p_sat;
  logic [SUM_W-1:0]  est_w;
  logic [SUM_W-1:0]  step_w;
  logic [SUM_W-1:0]  est_upd;

  // innovation and gate
  assign innov    = {meas_q[ALTITUDE_WIDTH-1], meas_q} - {est_q[ALTITUDE_WIDTH-1], est_q};
  assign mag_full = innov[INNOV_W-1] ? (INNOV_W'(0) - innov) : innov;
  assign gate_rej = CMP_W'(mag_full) > CMP_W'(cfg_i.gate_limit);
  assign rrun_inc = (rrun_q == '1) ? rrun_q : rrun_q + RUN_W'(1);
  assign reseed   = rrun_inc >= cfg_i.reseed_count;

  always_comb begin
    if (mode_q) begin
      cls = CLS_CLEAR;
    end else if (!init_q) begin
      cls = CLS_SEED;
    end else if (gate_rej) begin
      cls = CLS_REJECT;
    end else begin
      cls = CLS_UPDATE;
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = p_q;
    mul_b = GAIN_ONE - KQ_W'(k_q);
    case (cmd_i.op)
      OP_MUL_NOISE: begin
        mul_a = cfg_i.process_noise;
        mul_b = MUL_B_W'(dt_q);
      end
      OP_MUL_STEP: begin
        mul_a = MUL_A_W'(mag_q);
        mul_b = MUL_B_W'(k_q);
      end
      default: begin
        mul_a = p_q;
        mul_b = GAIN_ONE - KQ_W'(k_q);
      end
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // divider operands: noise scaling, then the gain with its quotient bounded to KQ_W bits
  assign ref_eff   = (cfg_i.reference_interval_ms == '0) ? MS_W'(1)
                                                         : cfg_i.reference_interval_ms;
  assign div_start = (cmd_i.op == OP_DIV_NOISE) || (cmd_i.op == OP_DIV_GAIN);

  always_comb begin
    if (cmd_i.op == OP_DIV_GAIN) begin
      div_rem_init = REM_W'(p_q[VAR_W-1:1]);
      div_dvd      = {p_q[0], {(DVD_W-1){1'b0}}};
      div_dvs      = denom_q;
      div_cnt      = DIV_CNT_W'(KQ_W);
    end else begin
      div_rem_init = '0;
      div_dvd      = prod_q[DVD_W-1:0];
      div_dvs      = DVS_W'(ref_eff);
      div_cnt      = DIV_CNT_W'(DVD_W);
    end
  end

  gskf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem_init),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .count_i    (div_cnt),
    .quot_o     (quot),
    .busy_o     (div_busy)
  );

  assign psum  = PSUM_W'(var_q) + PSUM_W'(quot);
  assign p_sat = (|psum[PSUM_W-1:VAR_W]) ? '1 : psum[VAR_W-1:0];

  assign est_w   = SUM_W'(est_q);
  assign step_w  = SUM_W'(step_q);
  assign est_upd = neg_q ? (est_w - step_w) : (est_w + step_w);

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 1'b0;
      est_q  <= '0;
      var_q  <= '0;
      rrun_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_EVAL: begin
          case (cls)
            CLS_CLEAR: init_q <= 1'b0;
            CLS_SEED: begin
              init_q <= 1'b1;
              est_q  <= meas_q;
              var_q  <= cfg_i.initial_variance;
              rrun_q <= '0;
            end
            CLS_REJECT: begin
              if (reseed) begin
                init_q <= 1'b1;
                est_q  <= meas_q;
                var_q  <= cfg_i.initial_variance;
                rrun_q <= '0;
              end else begin
                rrun_q <= rrun_inc;
              end
            end
            default: rrun_q <= '0;
          endcase
        end
        OP_UPDATE: begin
          est_q <= est_upd[ALTITUDE_WIDTH-1:0];
          var_q <= prod_q[VAR_W+K_W-1:K_W];
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        mode_q <= in_data_i.mode;
        meas_q <= in_data_i.measured_altitude;
        dt_q   <= (in_data_i.elapsed_ms > cfg_i.max_interval_ms) ? cfg_i.max_interval_ms
                                                                   : in_data_i.elapsed_ms;
      end
      OP_EVAL: begin
        acc_q <= (cls != CLS_CLEAR) && ((cls != CLS_REJECT) || reseed);
        neg_q <= innov[INNOV_W-1];
        mag_q <= mag_full[GATE_W-1:0];
      end
      OP_MUL_NOISE, OP_MUL_STEP: prod_q <= prod_d;
      OP_MUL_VAR: begin
        prod_q <= prod_d;
        step_q <= prod_q[GATE_W+K_W-1:K_W];
      end
      OP_PSUM: begin
        p_q     <= p_sat;
        denom_q <= DVS_W'(p_sat) + DVS_W'(cfg_i.measurement_noise);
      end
      OP_GAIN: begin
        if (denom_q == '0) begin
          k_q <= '0;
        end else if (quot[K_W]) begin
          k_q <= '1;
        end else begin
          k_q <= quot[K_W-1:0];
        end
      end
      OP_EMIT: begin
        out_q.accepted  <= acc_q;
        out_q.estimate  <= est_q;
        out_q.converged <= init_q && (var_q < cfg_i.converged_variance);
      end
      default: ;
    endcase
  end

  assign sts_o.cls      = cls;
  assign sts_o.div_busy = div_busy;
  assign out_data_o     = out_q;

endmodule

/* design/gskf_ctrl.sv */
// Controller: sequences one beat through the datapath and owns the handshakes.
// Depends on gskf_pkg for the command and status structs.
module gskf_ctrl import gskf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_MUL_NOISE,
    S_DIV_NOISE,
    S_WAIT_NOISE,
    S_DIV_GAIN,
    S_WAIT_GAIN,
    S_MUL_STEP,
    S_MUL_VAR,
    S_UPDATE,
    S_EMIT
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        emit;

  assign emit = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.op = OP_EVAL;
        state_d  = (sts_i.cls == CLS_UPDATE) ? S_MUL_NOISE : S_EMIT;
      end
      S_MUL_NOISE: begin
        cmd_o.op = OP_MUL_NOISE;
        state_d  = S_DIV_NOISE;
      end
      S_DIV_NOISE: begin
        cmd_o.op = OP_DIV_NOISE;
        state_d  = S_WAIT_NOISE;
      end
      S_WAIT_NOISE: begin
        // fold the predicted variance as soon as the quotient is final
        if (!sts_i.div_busy) begin
          cmd_o.op = OP_PSUM;
          state_d  = S_DIV_GAIN;
        end
      end
      S_DIV_GAIN: begin
        cmd_o.op = OP_DIV_GAIN;
        state_d  = S_WAIT_GAIN;
      end
      S_WAIT_GAIN: begin
        if (!sts_i.div_busy) begin
          cmd_o.op = OP_GAIN;
          state_d  = S_MUL_STEP;
        end
      end
      S_MUL_STEP: begin
        cmd_o.op = OP_MUL_STEP;
        state_d  = S_MUL_VAR;
      end
      S_MUL_VAR: begin
        cmd_o.op = OP_MUL_VAR;
        state_d  = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.op = OP_UPDATE;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        // hold until the result register is free
        if (emit) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

/* design/gated_scalar_kalman_filter.sv */
// Gated scalar Kalman filter: top level with configuration registers.
// Clear, seed and reject beats pass through the load, evaluate and emit states; an accepted
// update also runs the serial divider for a 48-bit noise quotient and a 17-bit gain quotient.
// Throughput: one beat at a time; the next beat is taken in the cycle after a result is loaded.
// Reset: filter unseeded, estimate and variance zero, registers at their defaults.
module gated_scalar_kalman_filter import gskf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t    cfg_q;
  dp_cmd_t cmd;
  dp_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INITIAL_VARIANCE:      cfg_q.initial_variance      <= cfg_wdata_i;
        CFG_GATE_LIMIT:            cfg_q.gate_limit            <= cfg_wdata_i[GATE_W-1:0];
        CFG_RESEED_COUNT:          cfg_q.reseed_count          <= cfg_wdata_i[RUN_W-1:0];
        CFG_MAX_INTERVAL_MS:       cfg_q.max_interval_ms       <= cfg_wdata_i[MS_W-1:0];
        CFG_PROCESS_NOISE:         cfg_q.process_noise         <= cfg_wdata_i;
        CFG_REFERENCE_INTERVAL_MS: cfg_q.reference_interval_ms <= cfg_wdata_i[MS_W-1:0];
        CFG_MEASUREMENT_NOISE:     cfg_q.measurement_noise     <= cfg_wdata_i;
        CFG_CONVERGED_VARIANCE:    cfg_q.converged_variance    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  gskf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gskf_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // an accepted beat keeps the input side busy in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a beat");

  // a new result only appears at the end of a beat's processing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o) && !in_stall_o)
    else $error("result raised outside of beat completion");

  // nothing is emitted in the cycle right after a beat is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result raised before the beat was evaluated");

endmodule

/* sim/tb_gated_scalar_kalman_filter.sv */
// Testbench for gated_scalar_kalman_filter: directed and random altitude beats, checked
// against an in-bench filter predictor held in a small scoreboard class.
// Depends on gskf_pkg and the gated_scalar_kalman_filter RTL only.
module tb_gated_scalar_kalman_filter;
  import gskf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;
  localparam int   PHASES      = 8;
  localparam int   PHASE_ITEMS = 156;
  localparam int   QUIET_LIMIT = 3000;
  localparam int   LONG_HOLD   = 300;

  class kalman_scoreboard;
    cfg_t                             cfg;
    logic                             seeded;
    logic signed [ALTITUDE_WIDTH-1:0] est;
    logic [VAR_W-1:0]                 variance;
    logic [RUN_W-1:0]                 reject_run;
    out_item_t                        pending_reports[$];
    int                               errors;

    function new();
      cfg        = CFG_RESET;
      seeded     = 1'b0;
      est        = '0;
      variance   = '0;
      reject_run = '0;
      errors     = 0;
    endfunction

    function void reseed_at(longint alt);
      est        = alt[ALTITUDE_WIDTH-1:0];
      variance   = cfg.initial_variance;
      reject_run = '0;
      seeded     = 1'b1;
    endfunction

    function out_item_t filter_update(in_item_t it);
      longint            meas, innov, e;
      longint unsigned   mag, ref_ms, dt, pn, p, denom, k, stp;
      out_item_t         r;
      meas       = longint'(it.measured_altitude);
      r.accepted = 1'b0;
      if (it.mode == MODE_CLEAR) begin
        seeded = 1'b0;
      end else if (!seeded) begin
        reseed_at(meas);
        r.accepted = 1'b1;
      end else begin
        e     = longint'(est);
        innov = meas - e;
        mag   = (innov < 0) ? -innov : innov;
        if (mag > 64'(cfg.gate_limit)) begin
          if (reject_run != {RUN_W{1'b1}}) reject_run++;
          if (reject_run >= cfg.reseed_count) begin
            reseed_at(meas);
            r.accepted = 1'b1;
          end
        end else begin
          ref_ms = (cfg.reference_interval_ms == 0) ? 64'd1 : 64'(cfg.reference_interval_ms);
          dt     = 64'((it.elapsed_ms > cfg.max_interval_ms) ? cfg.max_interval_ms
                                                              : it.elapsed_ms);
          pn     = 64'(cfg.process_noise);
          reject_run = '0;
          p = 64'(variance) + (pn * dt) / ref_ms;
          if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
          denom = p + 64'(cfg.measurement_noise);
          k     = (denom != 0) ? (p << 16) / denom : 64'd0;
          if (k > 64'd65535) k = 64'd65535;
          stp = (k * mag) >> 16;
          e   = (innov < 0) ? e - longint'(stp) : e + longint'(stp);
          est = e[ALTITUDE_WIDTH-1:0];
          variance   = VAR_W'((p * (64'd65536 - k)) >> 16);
          r.accepted = 1'b1;
        end
      end
      r.estimate  = est;
      r.converged = seeded && (variance < cfg.converged_variance);
      return r;
    endfunction

    function void note_measurement(in_item_t it);
      pending_reports.push_back(filter_update(it));
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: acc=%0d est=%0d conv=%0d",
                   got.accepted, got.estimate, got.converged);
        return;
      end
      want = pending_reports.pop_front();
      if (got.accepted !== want.accepted || got.estimate !== want.estimate ||
          got.converged !== want.converged) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected acc=%0d est=%0d conv=%0d, got acc=%0d est=%0d conv=%0d",
                   want.accepted, want.estimate, want.converged,
                   got.accepted, got.estimate, got.converged);
      end
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  kalman_scoreboard board = new();
  bit               in_gaps_on = 1'b1;
  bit               pressure_req = 1'b0;

  gated_scalar_kalman_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic in_item_t beat(logic mode, longint alt, int unsigned ms);
    in_item_t it;
    it.mode              = mode;
    it.measured_altitude = alt[ALTITUDE_WIDTH-1:0];
    it.elapsed_ms        = ms[MS_W-1:0];
    return it;
  endfunction

  function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi,
                                       logic [31:0] mn, logic [31:0] mx);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return mn;
    if (r == 1) return mx;
    return $urandom_range(hi, lo);
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    s.initial_variance      = pick(32'd65536, 32'd26214400, 32'd0, 32'hFFFF_FFFF);
    s.gate_limit            = GATE_W'(pick(32'd256, 32'd51200, 32'd0, 32'd8388607));
    s.reseed_count          = RUN_W'(pick(32'd1, 32'd6, 32'd1, 32'd255));
    s.max_interval_ms       = MS_W'(pick(32'd500, 32'd20000, 32'd1, 32'd65535));
    s.process_noise         = pick(32'd0, 32'd1048576, 32'd0, 32'hFFFF_FFFF);
    s.reference_interval_ms = MS_W'(pick(32'd100, 32'd5000, 32'd1, 32'd65535));
    s.measurement_noise     = pick(32'd4096, 32'd16777216, 32'd1, 32'hFFFF_FFFF);
    s.converged_variance    = pick(32'd16384, 32'd4194304, 32'd0, 32'hFFFF_FFFF);
    return s;
  endfunction

  // mostly measurements near the current estimate, some outliers and clears
  function automatic in_item_t random_measurement();
    in_item_t        it;
    int unsigned     r, d;
    longint          span, alt, lim;
    r   = $urandom_range(0, 99);
    d   = $urandom_range(0, 9);
    lim = longint'(1) << (ALTITUDE_WIDTH - 1);
    it.mode = (r < 4) ? MODE_CLEAR : MODE_UPDATE;
    if (d == 0)      it.elapsed_ms = '0;
    else if (d == 1) it.elapsed_ms = '1;
    else if (d < 4)  it.elapsed_ms = MS_W'($urandom());
    else             it.elapsed_ms = MS_W'($urandom_range(0, 2000));
    if (r < 12) begin
      it.measured_altitude = ALTITUDE_WIDTH'($urandom());
    end else begin
      span = longint'(board.cfg.gate_limit) + longint'(board.cfg.gate_limit) / 8 + 2;
      alt  = longint'(board.est) + longint'($urandom_range(0, 2 * span)) - span;
      if (alt < -lim) alt = -lim;
      if (alt > lim - 1) alt = lim - 1;
      it.measured_altitude = alt[ALTITUDE_WIDTH-1:0];
    end
    return it;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] register_value(cfg_t s, cfg_idx_e idx);
    case (idx)
      CFG_INITIAL_VARIANCE:      return s.initial_variance;
      CFG_GATE_LIMIT:            return CFG_DATA_W'(s.gate_limit);
      CFG_RESEED_COUNT:          return CFG_DATA_W'(s.reseed_count);
      CFG_MAX_INTERVAL_MS:       return CFG_DATA_W'(s.max_interval_ms);
      CFG_PROCESS_NOISE:         return s.process_noise;
      CFG_REFERENCE_INTERVAL_MS: return CFG_DATA_W'(s.reference_interval_ms);
      CFG_MEASUREMENT_NOISE:     return s.measurement_noise;
      default:                   return s.converged_variance;
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = in_gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    board.note_measurement(it);
  endtask

  // drop valid and wait until every expected result is back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_settings(input cfg_t s);
    cfg_idx_e idx;
    idx = idx.first();
    repeat (idx.num()) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= register_value(s, idx);
      @(posedge clk_i);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
    board.cfg = s;
  endtask

  initial begin : result_sink
    int          hold;
    int unsigned taken;
    bit          gaps_on;
    bit          long_hold_done;
    hold           = 0;
    taken          = 0;
    gaps_on        = 1'b1;
    long_hold_done = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        board.check_report(out_data_o);
        taken++;
        if (taken % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
        hold = gaps_on ? $urandom_range(0, 3) : 0;
      end
      // hold off long enough for the block to fill and stall its input
      if (pressure_req && !long_hold_done) begin
        hold           = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    cfg_t edge_low, edge_high;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_INITIAL_VARIANCE;
    cfg_wdata_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: clear while unseeded, seed at the top, gate edge, reseed by rejects
    send_item(beat(MODE_CLEAR,  24'h123456, 77));
    send_item(beat(MODE_UPDATE, 8388607, 0));
    send_item(beat(MODE_UPDATE, 8388607, 65535));
    send_item(beat(MODE_UPDATE, 8388607 - 12800, 1000));
    send_item(beat(MODE_UPDATE, -8388608, 1000));
    send_item(beat(MODE_UPDATE, -8388608, 1000));
    send_item(beat(MODE_UPDATE, -8388608, 1000));
    send_item(beat(MODE_CLEAR,  -1, 65535));
    send_item(beat(MODE_UPDATE, 0, 0));
    for (int i = 0; i < 8; i++)
      send_item(beat(MODE_UPDATE, (i % 2) ? -256 : 256, 1000));
    send_item(beat(MODE_UPDATE, 20000, 1000));
    send_item(beat(MODE_UPDATE, 0, 1000));
    send_item(beat(MODE_CLEAR,  0, 0));
    settle();

    // all-low registers: zero gain divisor, zero reference interval, instant reseed
    edge_low = '{initial_variance: 0, gate_limit: 0, reseed_count: 0, max_interval_ms: 1,
                 process_noise: 0, reference_interval_ms: 0, measurement_noise: 0,
                 converged_variance: 0};
    load_settings(edge_low);
    send_item(beat(MODE_UPDATE, 100, 5));
    send_item(beat(MODE_UPDATE, 100, 5));
    send_item(beat(MODE_UPDATE, 101, 5));
    settle();

    // mostly high registers, zero measurement noise and reference interval: saturated variance and gain
    edge_high = '{initial_variance: 32'hFFFF_FFFF, gate_limit: 8388607, reseed_count: 255,
                  max_interval_ms: 65535, process_noise: 32'hFFFF_FFFF,
                  reference_interval_ms: 0, measurement_noise: 0,
                  converged_variance: 32'hFFFF_FFFF};
    load_settings(edge_high);
    send_item(beat(MODE_CLEAR,  0, 0));
    send_item(beat(MODE_UPDATE, 0, 0));
    send_item(beat(MODE_UPDATE, 8388607, 65535));
    send_item(beat(MODE_UPDATE, -8388608, 0));
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      load_settings((ph == 0) ? CFG_RESET : random_settings());
      if (ph == 2) pressure_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) in_gaps_on = ($urandom_range(0, 2) != 0);
        send_item(random_measurement());
      end
      settle();
    end

    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
design/gskf_pkg.sv
design/gskf_div.sv
design/gskf_dp.sv
design/gskf_ctrl.sv
design/gated_scalar_kalman_filter.sv
sim/tb_gated_scalar_kalman_filter.sv
